/* hw/rtl/mks_pkg.sv */
// Package with the shared types and constants of the matrix keypad scanner.
`timescale 1ns / 1ps

package mks_pkg;

	localparam int MKS_ROWS = 4;
	localparam int MKS_COLS = 4;

	// Configuration register indexes.
	localparam logic [2:0] CFG_KEY_MAP_ROW0  = 3'd0;
	localparam logic [2:0] CFG_KEY_MAP_ROW1  = 3'd1;
	localparam logic [2:0] CFG_KEY_MAP_ROW2  = 3'd2;
	localparam logic [2:0] CFG_KEY_MAP_ROW3  = 3'd3;
	localparam logic [2:0] CFG_REPEAT_WINDOW = 3'd4;

	localparam logic [31:0] KEY_MAP_ROW0_RST  = 32'h4133_3231;
	localparam logic [31:0] KEY_MAP_ROW1_RST  = 32'h4236_3534;
	localparam logic [31:0] KEY_MAP_ROW2_RST  = 32'h4339_3837;
	localparam logic [31:0] KEY_MAP_ROW3_RST  = 32'h4423_302A;
	localparam logic [15:0] REPEAT_WINDOW_RST = 16'd200;

	localparam logic [7:0]  CHAR_LOWER_A = 8'h61;
	localparam logic [7:0]  CHAR_LOWER_D = 8'h64;
	localparam logic [7:0]  CASE_OFFSET  = 8'h20;
	localparam logic [7:0]  NO_KEY       = 8'h00;
	localparam logic [15:0] MS_MAX       = 16'hFFFF;

	// key_map[r][c] is the code of row r, column c.
	typedef logic [3:0][3:0][7:0] key_map_t;

	typedef struct packed {
		logic [3:0] col_levels;
		logic       ms_tick;
		logic       serial_valid;
		logic [7:0] serial_byte;
	} in_item_t;

	typedef struct packed {
		logic [3:0] row_drive;
		logic       key_valid;
		logic [7:0] key_code;
		logic       serial_accept;
		logic       key_activity;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  scan_row;
		logic        waiting_release;
		logic [1:0]  held_column;
		logic [7:0]  previous_key;
		logic [15:0] ms_since_key;
	} scan_state_t;

endpackage

/* hw/rtl/mks_step.sv */
// Next-state and result logic for one scanned item of the keypad scanner.
`timescale 1ns / 1ps

module mks_step #(
	parameter int ROWS = mks_pkg::MKS_ROWS,
	parameter int COLS = mks_pkg::MKS_COLS
) (
	input  mks_pkg::in_item_t    item,
	input  mks_pkg::scan_state_t cur,
	input  mks_pkg::key_map_t    key_map,
	input  logic [15:0]          repeat_window,
	output mks_pkg::scan_state_t nxt,
	output mks_pkg::out_item_t   result
);
	import mks_pkg::*;

	localparam logic [3:0] COL_MASK = 4'((1 << COLS) - 1);
	localparam logic [1:0] LAST_ROW = 2'(ROWS - 1);

	logic [3:0]  pressed;
	logic [15:0] ms_inc;
	logic [1:0]  low_col;
	logic [7:0]  scan_key;
	logic        try_serial;
	logic [7:0]  serial_ch;
	logic        ch_in_map;
	logic        accept;
	logic [7:0]  key;
	logic        report;
	logic [1:0]  row_after;
	logic        wait_after;
	logic [1:0]  held_after;

	assign pressed = ~item.col_levels & COL_MASK;
	assign ms_inc  = (item.ms_tick && cur.ms_since_key != MS_MAX) ?
		cur.ms_since_key + 16'd1 : cur.ms_since_key;

	always_comb begin
		priority if (pressed[0]) begin
			low_col = 2'd0;
		end else if (pressed[1]) begin
			low_col = 2'd1;
		end else if (pressed[2]) begin
			low_col = 2'd2;
		end else begin
			low_col = 2'd3;
		end
	end

	// Lowercase a to d fold to uppercase before the map lookup.
	assign serial_ch = (item.serial_byte >= CHAR_LOWER_A && item.serial_byte <= CHAR_LOWER_D) ?
		item.serial_byte - CASE_OFFSET : item.serial_byte;

	always_comb begin
		ch_in_map = 1'b0;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (key_map[r][c] == serial_ch) begin
					ch_in_map = 1'b1;
				end
			end
		end
	end

	always_comb begin
		scan_key   = NO_KEY;
		try_serial = 1'b0;
		row_after  = cur.scan_row;
		wait_after = cur.waiting_release;
		held_after = cur.held_column;
		if (cur.waiting_release) begin
			if (!pressed[cur.held_column]) begin
				scan_key   = key_map[cur.scan_row][cur.held_column];
				wait_after = 1'b0;
				row_after  = 2'd0;
				try_serial = (scan_key == NO_KEY);
			end
		end else if (pressed != 4'd0) begin
			held_after = low_col;
			wait_after = 1'b1;
		end else if (cur.scan_row >= LAST_ROW) begin
			try_serial = 1'b1;
			row_after  = 2'd0;
		end else begin
			row_after = cur.scan_row + 2'd1;
		end
	end

	assign accept = try_serial && item.serial_valid;
	assign key    = (accept && ch_in_map) ? serial_ch : scan_key;

	// A repeat of the last reported key is dropped inside the debounce window.
	assign report = (key != NO_KEY) &&
		!(key == cur.previous_key && ms_inc < repeat_window);

	assign nxt = '{
		scan_row:        row_after,
		waiting_release: wait_after,
		held_column:     held_after,
		previous_key:    report ? key : cur.previous_key,
		ms_since_key:    report ? 16'd0 : ms_inc
	};

	assign result.row_drive     = 4'hF & ~(4'b0001 << row_after);
	assign result.key_valid     = report;
	assign result.key_code      = report ? key : NO_KEY;
	assign result.serial_accept = accept;
	assign result.key_activity  = (pressed != 4'd0) || item.serial_valid;

endmodule

/* hw/rtl/matrix_keypad_scanner.sv */
// Top level of the 4x4 matrix keypad scanner with serial fallback.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-----------------------
//   in       | input     | in_valid / in_ready  | in_data  (in_item_t)
//   out      | output    | out_valid / out_ready| out_data (out_item_t)
//   cfg      | input     | cfg_we               | cfg_index, cfg_data
//
// Each item is held in the input register after acceptance, then the scan logic
// writes the result register and the state.
// One item is accepted every cycle while the output side keeps taking.
// A stalled output holds the result register and, behind it, the input
// register; in_ready drops only when both are full.
// Reset clears the scan state and loads the default key map and window.
`timescale 1ns / 1ps

module matrix_keypad_scanner #(
	parameter int ROWS = mks_pkg::MKS_ROWS,
	parameter int COLS = mks_pkg::MKS_COLS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mks_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output mks_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import mks_pkg::*;

	key_map_t    key_map_q;
	logic [15:0] repeat_window_q;
	scan_state_t state_q;
	scan_state_t state_nxt;
	in_item_t    item_s1;
	logic        valid_s1;
	out_item_t   result;
	logic        advance;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	mks_step #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_step (
		.item          (item_s1),
		.cur           (state_q),
		.key_map       (key_map_q),
		.repeat_window (repeat_window_q),
		.nxt           (state_nxt),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_map_q[0]    <= KEY_MAP_ROW0_RST;
			key_map_q[1]    <= KEY_MAP_ROW1_RST;
			key_map_q[2]    <= KEY_MAP_ROW2_RST;
			key_map_q[3]    <= KEY_MAP_ROW3_RST;
			repeat_window_q <= REPEAT_WINDOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_MAP_ROW0:  key_map_q[0] <= cfg_data;
				CFG_KEY_MAP_ROW1:  key_map_q[1] <= cfg_data;
				CFG_KEY_MAP_ROW2:  key_map_q[2] <= cfg_data;
				CFG_KEY_MAP_ROW3:  key_map_q[3] <= cfg_data;
				CFG_REPEAT_WINDOW: repeat_window_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
			state_q   <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid <= 1'b1;
				state_q   <= state_nxt;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			out_data <= result;
		end
	end

endmodule

/* hw/rtl/mks_checker.sv */
// Port-level checker for the keypad scanner, bound to the top level.
`timescale 1ns / 1ps

module mks_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input mks_pkg::out_item_t out_data
);
	import mks_pkg::*;

	// A stalled result transaction keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_key_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.key_valid |-> out_data.key_code != NO_KEY)
		else $error("reported key has code zero");

	a_no_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.key_valid |-> out_data.key_code == NO_KEY)
		else $error("key code set without a report");

	a_one_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones(out_data.row_drive) == 3)
		else $error("row drive does not select exactly one row");

	// A consumed serial byte was pending, so activity must show.
	a_accept_activity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.serial_accept |-> out_data.key_activity)
		else $error("serial byte consumed without activity");

endmodule

bind matrix_keypad_scanner mks_checker u_mks_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

/* verif/testbench.sv */
// Self-checking testbench for the matrix keypad scanner with serial fallback.
`timescale 1ns / 1ps

module testbench;
	import mks_pkg::*;

	// Mirrors the scanner state, predicts each result and checks results in order.
	class keypad_scoreboard;
		key_map_t    map;
		logic [15:0] window;
		scan_state_t st;
		out_item_t   expected_q[$];
		int          errors;
		int          n_in;
		int          n_out;
		int          n_keys;
		int          n_serial;
		int          n_suppressed;

		function new();
			map[0] = KEY_MAP_ROW0_RST;
			map[1] = KEY_MAP_ROW1_RST;
			map[2] = KEY_MAP_ROW2_RST;
			map[3] = KEY_MAP_ROW3_RST;
			window = REPEAT_WINDOW_RST;
			st = '0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
				CFG_KEY_MAP_ROW0:  map[0] = value;
				CFG_KEY_MAP_ROW1:  map[1] = value;
				CFG_KEY_MAP_ROW2:  map[2] = value;
				CFG_KEY_MAP_ROW3:  map[3] = value;
				CFG_REPEAT_WINDOW: window = value[15:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Advances the mirrored state by one transaction and queues the result it causes.
		function void note_input(in_item_t it);
			logic [3:0] pressed;
			logic [7:0] key;
			logic [7:0] ch;
			logic       try_serial;
			logic       accept;
			logic       report;
			logic       found;
			out_item_t  exp;
			pressed = ~it.col_levels;
			key = NO_KEY;
			try_serial = 1'b0;
			accept = 1'b0;
			report = 1'b0;
			found = 1'b0;
			n_in++;
			if (it.ms_tick && st.ms_since_key != MS_MAX)
				st.ms_since_key++;
			if (st.waiting_release) begin
				// The held column alone decides the release; other columns are ignored.
				if (!pressed[st.held_column]) begin
					key = map[st.scan_row][st.held_column];
					st.waiting_release = 1'b0;
					st.scan_row = '0;
					if (key == NO_KEY)
						try_serial = 1'b1;
				end
			end else if (pressed != '0) begin
				for (int c = MKS_COLS - 1; c >= 0; c--)
					if (pressed[c])
						st.held_column = 2'(c);
				st.waiting_release = 1'b1;
			end else if (st.scan_row == 2'(MKS_ROWS - 1)) begin
				try_serial = 1'b1;
				st.scan_row = '0;
			end else begin
				st.scan_row++;
			end
			if (try_serial && it.serial_valid) begin
				accept = 1'b1;
				n_serial++;
				ch = it.serial_byte;
				if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_D)
					ch = ch - CASE_OFFSET;
				// Every map entry counts, so a byte of zero matches a zero entry.
				for (int r = 0; r < 4; r++)
					for (int c = 0; c < 4; c++)
						if (map[r][c] == ch)
							found = 1'b1;
				if (found)
					key = ch;
			end
			if (key != NO_KEY) begin
				if (key == st.previous_key && st.ms_since_key < window) begin
					key = NO_KEY;
					n_suppressed++;
				end else begin
					st.previous_key = key;
					st.ms_since_key = '0;
					report = 1'b1;
					n_keys++;
				end
			end
			exp.row_drive = ~(4'b0001 << st.scan_row);
			exp.key_valid = report;
			exp.key_code = report ? key : NO_KEY;
			exp.serial_accept = accept;
			exp.key_activity = (pressed != '0) || it.serial_valid;
			expected_q.push_back(exp);
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				if (errors <= 20)
					$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
						$time, field, want, got);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp;
			n_out++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 20)
					$display("%0t: result with nothing expected, expected none, got 0x%0h",
						$time, got);
				return;
			end
			exp = expected_q.pop_front();
			compare_field("row_drive", exp.row_drive, got.row_drive);
			compare_field("key_valid", exp.key_valid, got.key_valid);
			compare_field("key_code", exp.key_code, got.key_code);
			compare_field("serial_accept", exp.serial_accept, got.serial_accept);
			compare_field("key_activity", exp.key_activity, got.key_activity);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	keypad_scoreboard sb = new();
	int burst_left = 0;
	bit hold_off_req = 1'b0;
	int n_settings = 0;

	matrix_keypad_scanner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	// Receiver: stretches of steady, random or patterned readiness, plus one long hold-off
	// whenever the stimulus asks for it.
	initial begin : receiver
		int stretch;
		int mode;
		int phase_cnt;
		stretch = 0;
		mode = 0;
		phase_cnt = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (80) @(posedge clk);
			end
			if (stretch == 0) begin
				mode = $urandom_range(0, 2);
				stretch = $urandom_range(5, 60);
			end
			stretch--;
			phase_cnt++;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= (phase_cnt % 5) < 3;
			endcase
		end
	end

	initial begin
		#40_000_000;
		$display("Run did not finish in time, %0d results still expected.", sb.pending());
		$display("testbench: errors");
		$finish;
	end

	// Offers one transaction and waits for it to be taken; the sender works in bursts.
	task automatic drive_item(input in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_input(it);
	endtask

	task automatic offer(input logic [3:0] cols, input logic tick, input logic sv,
			input logic [7:0] sbyte);
		in_item_t it;
		it.col_levels = cols;
		it.ms_tick = tick;
		it.serial_valid = sv;
		it.serial_byte = sbyte;
		drive_item(it);
	endtask

	// Idle transactions until the next one completes a full scan.
	task automatic scan_to_last_row();
		while (sb.st.waiting_release || sb.st.scan_row != 2'(MKS_ROWS - 1))
			offer(4'hF, 1'b0, 1'b0, NO_KEY);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	task automatic set_config(input key_map_t m, input logic [15:0] deb);
		write_reg(CFG_KEY_MAP_ROW0, m[0]);
		write_reg(CFG_KEY_MAP_ROW1, m[1]);
		write_reg(CFG_KEY_MAP_ROW2, m[2]);
		write_reg(CFG_KEY_MAP_ROW3, m[3]);
		write_reg(CFG_REPEAT_WINDOW, {16'h0000, deb});
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	function automatic key_map_t default_map();
		key_map_t m;
		m[0] = KEY_MAP_ROW0_RST;
		m[1] = KEY_MAP_ROW1_RST;
		m[2] = KEY_MAP_ROW2_RST;
		m[3] = KEY_MAP_ROW3_RST;
		return m;
	endfunction

	// Kinds: 0 default, 1 fully random, 2 few codes with zeros and repeats, 3 all ones, 4 all zero.
	function automatic key_map_t make_map(int kind);
		key_map_t m;
		logic [7:0] pool[6];
		pool = '{NO_KEY, 8'h41, 8'h42, 8'h31, CHAR_LOWER_A, 8'hFF};
		m = default_map();
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				case (kind)
					1: m[r][c] = 8'($urandom());
					2: m[r][c] = pool[$urandom_range(0, 5)];
					3: m[r][c] = 8'hFF;
					4: m[r][c] = NO_KEY;
					default: ;
				endcase
		return m;
	endfunction

	// Mostly well-formed press and release sequences, with serial bytes drawn from the map or elsewhere.
	function automatic in_item_t random_item(int tick_pct);
		in_item_t it;
		int pick;
		it.ms_tick = ($urandom_range(0, 99) < tick_pct);
		it.col_levels = 4'hF;
		if (sb.st.waiting_release) begin
			it.col_levels = 4'($urandom());
			it.col_levels[sb.st.held_column] = ($urandom_range(0, 99) >= 65);
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 20)
				it.col_levels = 4'($urandom_range(0, 14));
			else if (pick < 25)
				it.col_levels = 4'($urandom());
		end
		it.serial_valid = $urandom_range(0, 99) <
			((sb.st.scan_row == 2'(MKS_ROWS - 1) || sb.st.waiting_release) ? 50 : 20);
		pick = $urandom_range(0, 99);
		if (pick < 45)
			it.serial_byte = sb.map[$urandom_range(0, 3)][$urandom_range(0, 3)];
		else if (pick < 60)
			it.serial_byte = CHAR_LOWER_A + 8'($urandom_range(0, 3));
		else if (pick < 70)
			it.serial_byte = NO_KEY;
		else if (pick < 75)
			it.serial_byte = 8'hFF;
		else
			it.serial_byte = 8'($urandom());
		return it;
	endfunction

	initial begin
		key_map_t    m;
		logic [15:0] deb;
		int          tick_pct;
		int          kinds[6];
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_KEY_MAP_ROW0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part on the reset configuration.
		offer(4'hF, 1'b0, 1'b0, NO_KEY);
		offer(4'hF, 1'b1, 1'b1, 8'h78);          // pending byte ignored mid-scan
		offer(4'hF, 1'b0, 1'b0, 8'hFF);
		offer(4'hF, 1'b1, 1'b1, CHAR_LOWER_A);   // full scan takes it, reported as uppercase
		scan_to_last_row();
		offer(4'hF, 1'b0, 1'b1, CHAR_LOWER_A);   // same key inside the window is dropped
		offer(4'h0, 1'b1, 1'b1, 8'hFF);          // all columns low, lowest one is held
		offer(4'h0, 1'b0, 1'b0, NO_KEY);
		offer(4'hE, 1'b0, 1'b0, NO_KEY);
		offer(4'b0101, 1'b1, 1'b0, NO_KEY);
		offer(4'b0111, 1'b0, 1'b0, NO_KEY);
		scan_to_last_row();
		offer(4'b0111, 1'b0, 1'b0, NO_KEY);
		offer(4'hF, 1'b1, 1'b1, CHAR_LOWER_D);   // release wins over the pending byte
		drain();

		// A zero map entry sends the release to the serial path; a zero window allows repeats.
		m = default_map();
		m[0][0] = NO_KEY;
		set_config(m, 16'd0);
		offer(4'hE, 1'b0, 1'b0, NO_KEY);
		offer(4'hF, 1'b0, 1'b1, CHAR_LOWER_A + 8'd1);
		scan_to_last_row();
		offer(4'hF, 1'b0, 1'b1, CHAR_LOWER_A + 8'd1);
		scan_to_last_row();
		offer(4'hF, 1'b1, 1'b1, NO_KEY);
		scan_to_last_row();
		offer(4'hF, 1'b0, 1'b1, 8'hFF);
		drain();

		kinds = '{0, 1, 2, 3, 4, 2};
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: deb = REPEAT_WINDOW_RST;
				1: deb = 16'd0;
				2: deb = 16'($urandom_range(1, 30));
				3: deb = MS_MAX;
				4: deb = 16'($urandom_range(1, 5));
				default: deb = 16'd3;
			endcase
			set_config(make_map(kinds[ph]), deb);
			tick_pct = $urandom_range(5, 100);
			for (int i = 0; i < 170; i++) begin
				if (i == 20 && (ph == 0 || ph == 3))
					hold_off_req = 1'b1;
				drive_item(random_item(tick_pct));
			end
			drain();
		end
		repeat (10) @(posedge clk);

		if (sb.pending() != 0) begin
			sb.errors++;
			$display("%0t: %0d results never arrived", $time, sb.pending());
		end
		$display("Sent %0d transactions over %0d register settings, checked %0d results.",
			sb.n_in, n_settings, sb.n_out);
		$display("Keys reported %0d, repeats dropped %0d, serial bytes consumed %0d.",
			sb.n_keys, sb.n_suppressed, sb.n_serial);
		if (sb.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/mks_pkg.sv
hw/rtl/mks_step.sv
hw/rtl/matrix_keypad_scanner.sv
hw/rtl/mks_checker.sv
verif/testbench.sv
